FILE: rtl/ipr_pkg.sv
// Shared constants, types and codes for the infrared pulse rate classifier.
`default_nettype none

package ipr_pkg;

  // History geometry
  localparam int HIST_DEPTH = 5;
  localparam int PTR_W      = $clog2(HIST_DEPTH);

  // Field widths
  localparam int TS_W        = 32;
  localparam int CNT_W       = 16;
  localparam int DEB_W       = 16;
  localparam int WIN_W       = 24;
  localparam int THR_W       = 20;
  localparam int CONF_W      = 8;
  localparam int STREAK_W    = 8;
  localparam int OUT_TOTAL_W = 19;

  // History sum width and the width used to compare it with thresholds
  localparam int SUM_W = $clog2(HIST_DEPTH * ((2 ** CNT_W) - 1) + 1);
  localparam int CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Reset values of the configuration registers
  localparam logic [DEB_W-1:0]  DEB_RESET       = DEB_W'(100);
  localparam logic [WIN_W-1:0]  WIN_RESET       = WIN_W'(100000);
  localparam logic [THR_W-1:0]  HIGH_THR_RESET  = THR_W'(210);
  localparam logic [THR_W-1:0]  NOSRC_THR_RESET = THR_W'(50);
  localparam logic [CONF_W-1:0] CONF_HIGH_RESET = CONF_W'(2);
  localparam logic [CONF_W-1:0] CONF_LOW_RESET  = CONF_W'(15);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE     = 3'd0,
    CFG_WINDOW_LEN   = 3'd1,
    CFG_HIGH_THR     = 3'd2,
    CFG_NOSRC_THR    = 3'd3,
    CFG_CONFIRM_HIGH = 3'd4,
    CFG_CONFIRM_LOW  = 3'd5
  } cfg_idx_t;

  // Request operations
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_START  = 1'b1
  } op_t;

  // Verdict codes
  typedef enum logic [1:0] {
    VERDICT_NONE = 2'd0,
    VERDICT_LOW  = 2'd1,
    VERDICT_HIGH = 2'd2
  } verdict_t;

  // Configuration register contents
  typedef struct packed {
    logic [DEB_W-1:0]  debounce_time_us;
    logic [WIN_W-1:0]  window_length_us;
    logic [THR_W-1:0]  high_rate_threshold;
    logic [THR_W-1:0]  nosrc_threshold;
    logic [CONF_W-1:0] confirm_high_windows;
    logic [CONF_W-1:0] confirm_low_windows;
  } cfg_t;

  // Commands to the history memory
  typedef struct packed {
    logic             clear;
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic [CNT_W-1:0] wr_data;
    logic [PTR_W-1:0] rd_addr;
  } hist_cmd_t;

  // One result
  typedef struct packed {
    verdict_t               verdict;
    logic                   window_closed;
    logic [CNT_W-1:0]       window_pulses;
    logic [OUT_TOTAL_W-1:0] rolling_total;
    logic                   calibrating;
    logic                   detecting;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/ipr_if.sv
// Channel interfaces: sample requests, results and configuration writes.
`default_nettype none

interface ipr_in_if import ipr_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            operation;
  logic            pin_level;
  logic [TS_W-1:0] now_us;

  modport source (output valid, operation, pin_level, now_us, input ready);
  modport sink   (input valid, operation, pin_level, now_us, output ready);
endinterface

interface ipr_out_if import ipr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             verdict;
  logic                   window_closed;
  logic [CNT_W-1:0]       window_pulses;
  logic [OUT_TOTAL_W-1:0] rolling_total;
  logic                   calibrating;
  logic                   detecting;

  modport source (output valid, verdict, window_closed, window_pulses, rolling_total,
                  calibrating, detecting, input ready);
  modport sink   (input valid, verdict, window_closed, window_pulses, rolling_total,
                  calibrating, detecting, output ready);
endinterface

interface ipr_cfg_if import ipr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/ipr_cfg_regs.sv
// Configuration register file with its write channel.
`default_nettype none

module ipr_cfg_regs import ipr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  ipr_cfg_if.sink    cfg,
  output cfg_t       regs
);

  logic wr_fire;

  // Take a write every cycle
  assign cfg.ready = 1'b1;
  assign wr_fire   = cfg.valid & cfg.ready;

  // Decode the index; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.debounce_time_us     <= DEB_RESET;
      regs.window_length_us     <= WIN_RESET;
      regs.high_rate_threshold  <= HIGH_THR_RESET;
      regs.nosrc_threshold      <= NOSRC_THR_RESET;
      regs.confirm_high_windows <= CONF_HIGH_RESET;
      regs.confirm_low_windows  <= CONF_LOW_RESET;
    end else if (wr_fire) begin
      unique case (cfg.index)
        CFG_DEBOUNCE:     regs.debounce_time_us     <= cfg.data[DEB_W-1:0];
        CFG_WINDOW_LEN:   regs.window_length_us     <= cfg.data[WIN_W-1:0];
        CFG_HIGH_THR:     regs.high_rate_threshold  <= cfg.data[THR_W-1:0];
        CFG_NOSRC_THR:    regs.nosrc_threshold      <= cfg.data[THR_W-1:0];
        CFG_CONFIRM_HIGH: regs.confirm_high_windows <= cfg.data[CONF_W-1:0];
        CFG_CONFIRM_LOW:  regs.confirm_low_windows  <= cfg.data[CONF_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ipr_hist_mem.sv
// Window history memory with per-entry valid bits and a registered read port.
`default_nettype none

module ipr_hist_mem import ipr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire hist_cmd_t  cmd,
  output logic [CNT_W-1:0] rd_data
);

  logic [CNT_W-1:0]      mem [HIST_DEPTH];
  logic [HIST_DEPTH-1:0] valid;
  logic [CNT_W-1:0]      rd_raw;
  logic                  rd_valid;

  // Write port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= cmd.wr_data;
    end
  end

  // Read port; the read address never equals a same-cycle write address
  always_ff @(posedge clk) begin
    rd_raw <= mem[cmd.rd_addr];
  end

  // Track written entries; a clear empties the whole history at once
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        valid <= '0;
      end else if (cmd.wr_en) begin
        valid[cmd.wr_addr] <= 1'b1;
      end
      rd_valid <= ~cmd.clear & valid[cmd.rd_addr];
    end
  end

  // Unwritten entries read as zero
  assign rd_data = rd_valid ? rd_raw : '0;

endmodule

`default_nettype wire

FILE: rtl/ipr_out_buf.sv
// Two-slot output buffer: output register plus skid slot.
`default_nettype none

module ipr_out_buf import ipr_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         can_push,
  ipr_out_if.source    res
);

  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;
  logic    slot_free;

  assign can_push  = ~skid_valid;
  assign slot_free = ~out_valid | res.ready;

  // Fill the output slot first, park in the skid slot while it is held
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (slot_free) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_data  <= push_data;
        out_valid <= push;
      end
    end else if (push) begin
      skid_data  <= push_data;
      skid_valid <= 1'b1;
    end
  end

  // Drive the result channel
  assign res.valid         = out_valid;
  assign res.verdict       = out_data.verdict;
  assign res.window_closed = out_data.window_closed;
  assign res.window_pulses = out_data.window_pulses;
  assign res.rolling_total = out_data.rolling_total;
  assign res.calibrating   = out_data.calibrating;
  assign res.detecting     = out_data.detecting;

endmodule

`default_nettype wire

FILE: rtl/ir_pulse_rate_classifier_core.sv
// Top level: pulse counting, window history update and rate classification.
//
//   Channel     Dir  Handshake      Contents
//   sample_in   in   valid/ready    operation, pin_level, now_us
//   result_out  out  valid/ready    verdict, window_closed, window_pulses,
//                                   rolling_total, calibrating, detecting
//   cfg         in   valid/ready    register index, write data (always ready)
//
// One request per cycle unless the skid slot is full. Each result is
// registered in the output or skid slot. The history memory is read ahead at the
// next write slot, so its registered read data is ready when a window closes.
// Reset is synchronous; the history needs no clearing pass (valid bits).
// A held result parks in a skid slot; requests stall only when both are full.
`default_nettype none

module ir_pulse_rate_classifier_core import ipr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  ipr_in_if.sink     sample_in,
  ipr_out_if.source  result_out,
  ipr_cfg_if.sink    cfg
);

  cfg_t             regs;
  hist_cmd_t        hist_cmd;
  logic [CNT_W-1:0] hist_old;
  result_t          res_next;
  logic             can_push;
  logic             in_fire;

  // Detection state
  logic                active;
  logic                prev_level;
  logic [CNT_W-1:0]    pulse_cnt;
  logic [TS_W-1:0]     last_edge;
  logic [TS_W-1:0]     win_start;
  logic [PTR_W-1:0]    ptr;
  logic                filled;
  logic [SUM_W-1:0]    total;
  logic [STREAK_W-1:0] high_streak;
  logic [STREAK_W-1:0] low_streak;

  logic                active_next;
  logic                prev_level_next;
  logic [CNT_W-1:0]    pulse_cnt_next;
  logic [TS_W-1:0]     last_edge_next;
  logic [TS_W-1:0]     win_start_next;
  logic [PTR_W-1:0]    ptr_next;
  logic                filled_next;
  logic [SUM_W-1:0]    total_next;
  logic [STREAK_W-1:0] high_streak_next;
  logic [STREAK_W-1:0] low_streak_next;

  // Per-request helpers
  logic [CNT_W-1:0]    cnt_upd;
  logic [TS_W-1:0]     edge_gap;
  logic [TS_W-1:0]     win_gap;
  logic                win_close;
  logic [CMP_W-1:0]    total_cmp;
  logic                ptr_last;

  ipr_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  ipr_hist_mem u_hist (
    .clk     (clk),
    .rst     (rst),
    .cmd     (hist_cmd),
    .rd_data (hist_old)
  );

  ipr_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire),
    .push_data (res_next),
    .can_push  (can_push),
    .res       (result_out)
  );

  assign sample_in.ready = can_push;
  assign in_fire         = sample_in.valid & can_push;

  assign edge_gap  = sample_in.now_us - last_edge;
  assign win_gap   = sample_in.now_us - win_start;
  assign win_close = win_gap >= TS_W'(regs.window_length_us);
  assign ptr_last  = ptr == PTR_W'(HIST_DEPTH - 1);

  // Next state and result for the request on the input
  always_comb begin
    active_next      = active;
    prev_level_next  = prev_level;
    pulse_cnt_next   = pulse_cnt;
    last_edge_next   = last_edge;
    win_start_next   = win_start;
    ptr_next         = ptr;
    filled_next      = filled;
    total_next       = total;
    high_streak_next = high_streak;
    low_streak_next  = low_streak;
    cnt_upd          = pulse_cnt;
    total_cmp        = '0;

    hist_cmd.clear   = 1'b0;
    hist_cmd.wr_en   = 1'b0;
    hist_cmd.wr_addr = ptr;
    hist_cmd.wr_data = '0;

    res_next.verdict       = VERDICT_NONE;
    res_next.window_closed = 1'b0;
    res_next.window_pulses = '0;

    if (in_fire) begin
      if (sample_in.operation == OP_START) begin
        // Start: wipe counts and history, latch pin and window start
        active_next      = 1'b1;
        prev_level_next  = sample_in.pin_level;
        pulse_cnt_next   = '0;
        last_edge_next   = '0;
        win_start_next   = sample_in.now_us;
        ptr_next         = '0;
        filled_next      = 1'b0;
        total_next       = '0;
        high_streak_next = '0;
        low_streak_next  = '0;
        hist_cmd.clear   = 1'b1;
      end else if (active) begin
        // Count a debounced rising edge
        if (sample_in.pin_level && !prev_level &&
            edge_gap > TS_W'(regs.debounce_time_us)) begin
          if (pulse_cnt != '1) begin
            cnt_upd = pulse_cnt + CNT_W'(1);
          end
          last_edge_next = sample_in.now_us;
        end
        prev_level_next = sample_in.pin_level;
        pulse_cnt_next  = cnt_upd;

        if (win_close) begin
          // Close the window: store its count, advance the slot, update the sum
          res_next.window_closed = 1'b1;
          res_next.window_pulses = cnt_upd;
          pulse_cnt_next         = '0;
          hist_cmd.wr_en         = 1'b1;
          hist_cmd.wr_data       = cnt_upd;
          ptr_next               = ptr_last ? '0 : ptr + PTR_W'(1);
          filled_next            = filled | ptr_last;
          total_next             = total - SUM_W'(hist_old) + SUM_W'(cnt_upd);
          win_start_next         = sample_in.now_us;
          total_cmp              = CMP_W'(total_next);

          // Classify once the history is full
          if (filled_next) begin
            if (total_cmp < CMP_W'(regs.nosrc_threshold)) begin
              high_streak_next = '0;
              low_streak_next  = '0;
            end else if (total_cmp > CMP_W'(regs.high_rate_threshold)) begin
              if (high_streak != '1) begin
                high_streak_next = high_streak + STREAK_W'(1);
              end
              low_streak_next = '0;
              if (high_streak_next >= regs.confirm_high_windows) begin
                res_next.verdict = VERDICT_HIGH;
                active_next      = 1'b0;
              end
            end else begin
              if (low_streak != '1) begin
                low_streak_next = low_streak + STREAK_W'(1);
              end
              high_streak_next = '0;
              if (low_streak_next >= regs.confirm_low_windows) begin
                res_next.verdict = VERDICT_LOW;
                active_next      = 1'b0;
              end
            end
          end
        end
      end
    end

    // Read ahead at the slot the next close will overwrite
    hist_cmd.rd_addr = ptr_next;

    res_next.rolling_total = (CMP_W'(total_next) > CMP_W'((2 ** OUT_TOTAL_W) - 1)) ?
                             '1 : OUT_TOTAL_W'(total_next);
    res_next.calibrating   = ~filled_next;
    res_next.detecting     = active_next;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      prev_level  <= 1'b0;
      pulse_cnt   <= '0;
      last_edge   <= '0;
      win_start   <= '0;
      ptr         <= '0;
      filled      <= 1'b0;
      total       <= '0;
      high_streak <= '0;
      low_streak  <= '0;
    end else begin
      active      <= active_next;
      prev_level  <= prev_level_next;
      pulse_cnt   <= pulse_cnt_next;
      last_edge   <= last_edge_next;
      win_start   <= win_start_next;
      ptr         <= ptr_next;
      filled      <= filled_next;
      total       <= total_next;
      high_streak <= high_streak_next;
      low_streak  <= low_streak_next;
    end
  end

endmodule

`default_nettype wire
